// ===== rtl/pfa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the P-256 field arithmetic unit.
// No dependencies; used by the top level, the front end and the back end.
package pfa_pkg;

   localparam int WordBits = 256;
   // signed reduction accumulator: sum of Solinas terms stays within +/-2^261
   localparam int AccBits  = 262;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_NEG = 3'd2;
   localparam logic [2:0] OP_MUL = 3'd3;
   localparam logic [2:0] OP_SQR = 3'd4;
   localparam logic [2:0] OP_INV = 3'd5;

   localparam logic [WordBits-1:0] P_MOD =
      256'hFFFFFFFF00000001_0000000000000000_00000000FFFFFFFF_FFFFFFFFFFFFFFFF;
   localparam logic [WordBits-1:0] INV_EXP =
      256'hFFFFFFFF00000001_0000000000000000_00000000FFFFFFFF_FFFFFFFFFFFFFFFD;

   // top exponent bit handled after the initial copy of the operand
   localparam logic [7:0] INV_TOP_BIT = 8'd254;

   typedef enum logic [1:0] {
      KIND_LIN,
      KIND_MUL,
      KIND_INV
   } kind_type;

   typedef struct packed {
      logic [2:0]          op;
      kind_type            kind;
      logic [WordBits-1:0] a;
      logic [WordBits-1:0] b;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_RED,
      B_FIX,
      B_DONE
   } back_state_type;

endpackage

// ===== rtl/pfa_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the P-256 field unit.
// Depends on nothing but plain logic types.
interface pfa_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [63:0] a_limb0;
   logic [63:0] a_limb1;
   logic [63:0] a_limb2;
   logic [63:0] a_limb3;
   logic [63:0] b_limb0;
   logic [63:0] b_limb1;
   logic [63:0] b_limb2;
   logic [63:0] b_limb3;
   modport source (output valid, req_type, a_limb0, a_limb1, a_limb2, a_limb3,
                   b_limb0, b_limb1, b_limb2, b_limb3, input ready);
   modport sink (input valid, req_type, a_limb0, a_limb1, a_limb2, a_limb3,
                 b_limb0, b_limb1, b_limb2, b_limb3, output ready);
endinterface

interface pfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] res_limb0;
   logic [63:0] res_limb1;
   logic [63:0] res_limb2;
   logic [63:0] res_limb3;
   modport source (output valid, res_limb0, res_limb1, res_limb2, res_limb3,
                   input ready);
   modport sink (input valid, res_limb0, res_limb1, res_limb2, res_limb3,
                 output ready);
endinterface

// ===== rtl/p256_field_alu_top.sv =====
`timescale 1ns / 1ps
// P-256 field arithmetic unit: request queue front end and execution back end.
// Depends on pfa_pkg, pfa_if, pfa_front and pfa_back.
//
// Usage: send one beat on req_ch (valid/ready) with req_type and operands a
// and b as four 64-bit limbs; one beat with the result returns on rsp_ch.
// Square, negate and inverse ignore b; codes 6 and 7 return zero.
// A two-entry queue sits between the front and back, so new requests are
// taken while the back end works or while a result waits on rsp_ch.
// Sequence, after the beat reaches the back end:
//   add, sub, neg, undefined: straight to the result register.
//   mul, square: a load state, the word products on the shared 32x32 multiplier,
//     the nine Solinas reduction terms and then the correction steps.
//   inverse: 255 squarings plus 127 multiplies by a, each product run through
//     the multiply, reduction and correction states.
// One item is in the back end at a time and its result beat has a state of
// its own, so the next item is taken only once that beat is accepted. Reset
// empties the queue and drops any pending result. While rsp_ch is stalled the
// result holds and the back end waits; the queue fills and req_ch ready drops.
module p256_field_alu_top (
   input  logic      clock,
   input  logic      reset,
   pfa_req_if.sink   req_ch,
   pfa_rsp_if.source rsp_ch
);

   pfa_pkg::head_type head;
   logic              pop;

   pfa_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .pop    (pop),
      .head   (head)
   );

   pfa_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== rtl/pfa_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request beats, classifies them and queues them.
// Depends on pfa_pkg and pfa_req_if.
module pfa_front (
   input  logic          clock,
   input  logic          reset,
   pfa_req_if.sink       req_ch,
   input  logic          pop,
   output pfa_pkg::head_type head
);

   pfa_pkg::item_type q_ff [2];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;
   pfa_pkg::item_type cls;
   logic              push;

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push = req_ch.valid && req_ch.ready;

   always_comb begin
      cls.op = req_ch.req_type;
      cls.a  = {req_ch.a_limb3, req_ch.a_limb2, req_ch.a_limb1, req_ch.a_limb0};
      cls.b  = {req_ch.b_limb3, req_ch.b_limb2, req_ch.b_limb1, req_ch.b_limb0};
      case (req_ch.req_type)
         pfa_pkg::OP_MUL: cls.kind = pfa_pkg::KIND_MUL;
         pfa_pkg::OP_SQR: begin
            cls.kind = pfa_pkg::KIND_MUL;
            cls.b    = cls.a;
         end
         pfa_pkg::OP_INV: cls.kind = pfa_pkg::KIND_INV;
         default:         cls.kind = pfa_pkg::KIND_LIN;
      endcase
   end

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= cls;
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rd_ff];

endmodule

// ===== rtl/pfa_back.sv =====
`timescale 1ns / 1ps
// Back end: linear ops, word-serial 32x32 multiplier, Solinas reduction
// and the square-and-multiply inversion sequencer. Depends on pfa_pkg and pfa_rsp_if.
module pfa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  pfa_pkg::head_type      head,
   output logic                   pop,
   pfa_rsp_if.source              rsp_ch
);

   pfa_pkg::back_state_type state_ff, state_in;
   logic                    inv_ff, inv_in;
   logic                    phase_ff, phase_in;
   logic [7:0]              bit_ff, bit_in;
   logic [255:0]            x_ff, x_in, y_ff, y_in, a_ff, a_in;
   logic [31:0]             w_ff [16];
   logic [31:0]             w_in [16];
   logic [2:0]              i_ff, i_in, j_ff, j_in;
   logic [31:0]             mac_hi_ff, mac_hi_in;
   logic [3:0]              k_ff, k_in;
   logic signed [pfa_pkg::AccBits-1:0] acc_ff, acc_in;
   logic [255:0]            res_ff, res_in;

   logic [511:0]            cw;
   logic [255:0]            term;
   logic signed [pfa_pkg::AccBits-1:0] term_x;
   logic [31:0]             xw, yw;
   logic [63:0]             pp, cur;
   logic [3:0]              widx;
   logic [255:0]            lin_res, prod;
   logic [256:0]            s_add, s_fix, s_sub;

   function automatic logic [31:0] wd(input logic [511:0] c, input int n);
      wd = c[n*32 +: 32];
   endfunction

   // Solinas terms, word 7 down to word 0
   always_comb begin
      case (k_ff)
         4'd0: term = cw[255:0];
         4'd1: term = {wd(cw,15), wd(cw,14), wd(cw,13), wd(cw,12), wd(cw,11),
                       96'd0};
         4'd2: term = {32'd0, wd(cw,15), wd(cw,14), wd(cw,13), wd(cw,12), 96'd0};
         4'd3: term = {wd(cw,15), wd(cw,14), 96'd0, wd(cw,10), wd(cw,9),
                       wd(cw,8)};
         4'd4: term = {wd(cw,8), wd(cw,13), wd(cw,15), wd(cw,14), wd(cw,13),
                       wd(cw,11), wd(cw,10), wd(cw,9)};
         4'd5: term = {wd(cw,10), wd(cw,8), 96'd0, wd(cw,13), wd(cw,12),
                       wd(cw,11)};
         4'd6: term = {wd(cw,11), wd(cw,9), 64'd0, wd(cw,15), wd(cw,14),
                       wd(cw,13), wd(cw,12)};
         4'd7: term = {wd(cw,12), 32'd0, wd(cw,10), wd(cw,9), wd(cw,8),
                       wd(cw,15), wd(cw,14), wd(cw,13)};
         4'd8: term = {wd(cw,13), 32'd0, wd(cw,11), wd(cw,10), wd(cw,9), 32'd0,
                       wd(cw,15), wd(cw,14)};
         default: term = '0;
      endcase
      if (k_ff == 4'd1 || k_ff == 4'd2) term_x = {5'd0, term, 1'b0};
      else                              term_x = {6'd0, term};
   end

   always_comb begin
      for (int n = 0; n < 16; n++) cw[n*32 +: 32] = w_ff[n];
   end

   // linear ops straight off the queue head
   always_comb begin
      s_add = {1'b0, head.item.a} + {1'b0, head.item.b};
      s_fix = s_add - {1'b0, pfa_pkg::P_MOD};
      s_sub = {1'b0, head.item.a} - {1'b0, head.item.b};
      case (head.item.op)
         pfa_pkg::OP_ADD: lin_res = (s_add >= {1'b0, pfa_pkg::P_MOD}) ?
                                    s_fix[255:0] : s_add[255:0];
         pfa_pkg::OP_SUB: lin_res = s_sub[256] ? s_sub[255:0] + pfa_pkg::P_MOD :
                                    s_sub[255:0];
         pfa_pkg::OP_NEG: lin_res = (head.item.a != '0) ?
                                    pfa_pkg::P_MOD - head.item.a : '0;
         default:         lin_res = '0;
      endcase
   end

   assign xw   = x_ff[{i_ff, 5'd0} +: 32];
   assign yw   = y_ff[{j_ff, 5'd0} +: 32];
   assign pp   = xw * yw;
   assign widx = {1'b0, i_ff} + {1'b0, j_ff};
   assign cur  = {32'd0, w_ff[widx]} + pp + {32'd0, mac_hi_ff};
   assign prod = acc_ff[255:0];
   assign pop  = (state_ff == pfa_pkg::B_IDLE) && head.valid;

   always_comb begin
      state_in  = state_ff;
      inv_in    = inv_ff;
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      a_in      = a_ff;
      w_in      = w_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      mac_hi_in = mac_hi_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      res_in    = res_ff;
      case (state_ff)
         pfa_pkg::B_IDLE: begin
            if (head.valid) begin
               a_in      = head.item.a;
               x_in      = head.item.a;
               y_in      = head.item.b;
               i_in      = '0;
               j_in      = '0;
               mac_hi_in = '0;
               phase_in  = 1'b0;
               bit_in    = pfa_pkg::INV_TOP_BIT;
               for (int n = 0; n < 16; n++) w_in[n] = '0;
               case (head.item.kind)
                  pfa_pkg::KIND_MUL: begin
                     inv_in   = 1'b0;
                     state_in = pfa_pkg::B_MUL;
                  end
                  pfa_pkg::KIND_INV: begin
                     inv_in   = 1'b1;
                     y_in     = head.item.a;
                     state_in = pfa_pkg::B_MUL;
                  end
                  default: begin
                     res_in   = lin_res;
                     state_in = pfa_pkg::B_DONE;
                  end
               endcase
            end
         end
         pfa_pkg::B_MUL: begin
            w_in[widx] = cur[31:0];
            if (j_ff == 3'd7) begin
               w_in[{1'b1, i_ff}] = cur[63:32];
               mac_hi_in = '0;
               j_in      = '0;
               i_in      = i_ff + 3'd1;
               if (i_ff == 3'd7) begin
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = pfa_pkg::B_RED;
               end
            end else begin
               mac_hi_in = cur[63:32];
               j_in      = j_ff + 3'd1;
            end
         end
         pfa_pkg::B_RED: begin
            if (k_ff <= 4'd4) acc_in = acc_ff + term_x;
            else              acc_in = acc_ff - term_x;
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd8) state_in = pfa_pkg::B_FIX;
         end
         pfa_pkg::B_FIX: begin
            if (acc_ff[pfa_pkg::AccBits-1]) begin
               acc_in = acc_ff + $signed({6'd0, pfa_pkg::P_MOD});
            end else if (acc_ff >= $signed({6'd0, pfa_pkg::P_MOD})) begin
               acc_in = acc_ff - $signed({6'd0, pfa_pkg::P_MOD});
            end else begin
               // product reduced: finish or schedule the next exponent step
               i_in      = '0;
               j_in      = '0;
               mac_hi_in = '0;
               for (int n = 0; n < 16; n++) w_in[n] = '0;
               x_in     = prod;
               if (!inv_ff) begin
                  res_in   = prod;
                  state_in = pfa_pkg::B_DONE;
               end else if (!phase_ff && pfa_pkg::INV_EXP[bit_ff]) begin
                  y_in     = a_ff;
                  phase_in = 1'b1;
                  state_in = pfa_pkg::B_MUL;
               end else if (bit_ff == 8'd0) begin
                  res_in   = prod;
                  state_in = pfa_pkg::B_DONE;
               end else begin
                  bit_in   = bit_ff - 8'd1;
                  y_in     = prod;
                  phase_in = 1'b0;
                  state_in = pfa_pkg::B_MUL;
               end
            end
         end
         pfa_pkg::B_DONE: begin
            if (rsp_ch.ready) state_in = pfa_pkg::B_IDLE;
         end
         default: state_in = pfa_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pfa_pkg::B_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      inv_ff    <= inv_in;
      phase_ff  <= phase_in;
      bit_ff    <= bit_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      a_ff      <= a_in;
      w_ff      <= w_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      mac_hi_ff <= mac_hi_in;
      k_ff      <= k_in;
      acc_ff    <= acc_in;
      res_ff    <= res_in;
   end

   assign rsp_ch.valid     = (state_ff == pfa_pkg::B_DONE);
   assign rsp_ch.res_limb0 = res_ff[63:0];
   assign rsp_ch.res_limb1 = res_ff[127:64];
   assign rsp_ch.res_limb2 = res_ff[191:128];
   assign rsp_ch.res_limb3 = res_ff[255:192];

endmodule

// ===== rtl/pfa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for p256_field_alu_top, bound onto the top level.
// Depends only on the top level's port signals.
module pfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_limb0,
   input logic [63:0] rsp_limb3
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_limb0) && $stable(rsp_limb3))
      else $error("response payload changed while stalled");

   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("queue not empty after reset");

endmodule

bind p256_field_alu_top pfa_checker u_pfa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_limb0 (rsp_ch.res_limb0),
   .rsp_limb3 (rsp_ch.res_limb3)
);
